// ===== hw/rtl/euler_face_flux_rusanov_core_defines.svh =====
// Assertion macros shared by the flux core RTL.
`ifndef EULER_FACE_FLUX_RUSANOV_CORE_DEFINES_SVH
`define EULER_FACE_FLUX_RUSANOV_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define EFFR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("effr assertion failed");
// Antecedent implies consequent in the same cycle.
`define EFFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("effr assertion failed");
// Antecedent implies consequent in the next cycle.
`define EFFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("effr assertion failed");
`else
`define EFFR_ASSERT(label, cond)
`define EFFR_ASSERT_IMPL(label, ante, cons)
`define EFFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/effr_pkg.sv =====
package effr_pkg;

  localparam int Q_W     = 32;
  localparam int GAMMA_W = 18;
  localparam int ROOT_W  = 24;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_ONE = 32'sd65536;
  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;

  // Wall modes
  localparam logic [1:0] WALL_INTERIOR    = 2'd0;
  localparam logic [1:0] WALL_LEFT_GHOST  = 2'd1;
  localparam logic [1:0] WALL_RIGHT_GHOST = 2'd2;
  localparam logic [1:0] WALL_UNUSED      = 2'd3;

  // Register word index
  localparam logic REG_GAMMA = 1'b0;

  typedef struct packed {
    q_t         left_density;
    q_t         left_mom_x;
    q_t         left_mom_y;
    q_t         left_energy;
    q_t         right_density;
    q_t         right_mom_x;
    q_t         right_mom_y;
    q_t         right_energy;
    logic       normal_axis;
    logic [1:0] wall_mode;
  } face_t;

  typedef struct packed {
    q_t flux_mass;
    q_t flux_mom_x;
    q_t flux_mom_y;
    q_t flux_energy;
  } flux_t;

  typedef struct packed {
    q_t rho;
    q_t mom_x;
    q_t mom_y;
    q_t energy;
  } state_t;

  typedef struct packed {
    state_t st;
    q_t     f_mass;
    q_t     f_x;
    q_t     f_y;
    q_t     f_e;
    q_t     speed;
  } side_res_t;

  function automatic q_t sat33(input logic signed [Q_W:0] x);
    if (x[Q_W] != x[Q_W-1]) return x[Q_W] ? Q_MIN : Q_MAX;
    return x[Q_W-1:0];
  endfunction

  function automatic q_t sat48(input logic signed [47:0] x);
    if (x[47:Q_W-1] != {17{x[47]}}) return x[47] ? Q_MIN : Q_MAX;
    return x[Q_W-1:0];
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] pr;
    pr = a * b;
    return sat48(pr[63:16]);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat33({a[Q_W-1], a} + {b[Q_W-1], b});
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat33({a[Q_W-1], a} - {b[Q_W-1], b});
  endfunction

  function automatic q_t qneg(input q_t a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic q_t qabs(input q_t a);
    return a[Q_W-1] ? qneg(a) : a;
  endfunction

endpackage

// ===== hw/rtl/effr_div.sv =====
module effr_div #(
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  effr_pkg::q_t   num,
  input  effr_pkg::q_t   den,
  input  logic [SW-1:0]  side_in,
  output logic           out_valid,
  output effr_pkg::q_t   quo,
  output logic [SW-1:0]  side_out
);
  import effr_pkg::*;

  localparam int STEPS = Q_W;

  logic          vld [0:STEPS];
  logic          neg [0:STEPS];
  logic          ovf [0:STEPS];
  logic [Q_W-1:0] rem [0:STEPS];
  logic [Q_W-1:0] dvd [0:STEPS];
  logic [Q_W-1:0] qb  [0:STEPS];
  logic [Q_W-1:0] dsr [0:STEPS];
  logic [SW-1:0] sd  [0:STEPS];

  logic [Q_W-1:0] mag;
  logic [Q_W-1:0] hi;
  logic           ovf_c;

  // Magnitude of the numerator; the high half decides overflow up front
  assign mag   = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
  assign hi    = {16'b0, mag[Q_W-1:16]};
  assign ovf_c = hi >= Q_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= num[Q_W-1];
      ovf[0] <= ovf_c;
      rem[0] <= ovf_c ? '0 : hi;
      dvd[0] <= {mag[15:0], 16'b0};
      qb[0]  <= '0;
      dsr[0] <= Q_W'(den);
      sd[0]  <= side_in;
    end
  end

  // One quotient bit per stage, restoring
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [Q_W:0] trial;
    logic         fits;

    assign trial = {rem[k-1], dvd[k-1][Q_W-1]};
    assign fits  = trial >= {1'b0, dsr[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= fits ? Q_W'(trial - {1'b0, dsr[k-1]}) : trial[Q_W-1:0];
        dvd[k] <= {dvd[k-1][Q_W-2:0], 1'b0};
        qb[k]  <= {qb[k-1][Q_W-2:0], fits};
        neg[k] <= neg[k-1];
        ovf[k] <= ovf[k-1];
        dsr[k] <= dsr[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  // Apply sign and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= sd[STEPS];
      if (!neg[STEPS]) begin
        quo <= (ovf[STEPS] || qb[STEPS][Q_W-1]) ? Q_MAX : q_t'(qb[STEPS]);
      end else begin
        quo <= (ovf[STEPS] || (qb[STEPS] > Q_W'(Q_MIN))) ? Q_MIN : q_t'(-qb[STEPS]);
      end
    end
  end

endmodule

// ===== hw/rtl/effr_sqrt.sv =====
module effr_sqrt #(
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  effr_pkg::q_t                x,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [effr_pkg::ROOT_W-1:0] root,
  output logic [SW-1:0]               side_out
);
  import effr_pkg::*;

  localparam int RW = 2 * ROOT_W;

  logic              vld [0:ROOT_W];
  logic [RW-1:0]     rem [0:ROOT_W];
  logic [ROOT_W-1:0] rt  [0:ROOT_W];
  logic [SW-1:0]     sd  [0:ROOT_W];

  // Radicand is x scaled by 2^16; negative input reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= x[Q_W-1] ? '0 : RW'({x[Q_W-2:0], 16'b0});
      rt[0]  <= '0;
      sd[0]  <= side_in;
    end
  end

  // One root bit per stage, most significant first
  for (genvar s = 1; s <= ROOT_W; s++) begin : g_bit
    localparam int B = ROOT_W - s;
    logic [RW-1:0] trial;
    logic          fits;

    assign trial = (RW'(rt[s-1]) << (B + 1)) + (RW'(1) << (2 * B));
    assign fits  = rem[s-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= fits ? rem[s-1] - trial : rem[s-1];
        rt[s]  <= fits ? (rt[s-1] | (ROOT_W'(1) << B)) : rt[s-1];
        sd[s]  <= sd[s-1];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = sd[ROOT_W];

endmodule

// ===== hw/rtl/effr_side.sv =====
module effr_side (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [effr_pkg::GAMMA_W-1:0] gamma,
  input  logic                         in_valid,
  input  logic                         normal_axis,
  input  effr_pkg::state_t             st,
  output logic                         out_valid,
  output effr_pkg::side_res_t          res
);
  import effr_pkg::*;

  typedef struct packed {
    logic n;
    q_t   rho;
    q_t   mx;
    q_t   my;
  } du_side_t;

  typedef struct packed {
    logic n;
    q_t   rho;
    q_t   mx;
    q_t   my;
    q_t   e;
    q_t   un;
  } base_t;

  typedef struct packed {
    base_t b;
    q_t    fn;
    q_t    ft;
    q_t    fe;
  } tail_t;

  q_t g_q;
  q_t gm1;

  assign g_q = q_t'({{(Q_W-GAMMA_W){1'b0}}, gamma});
  assign gm1 = g_q - Q_ONE;

  // Velocities
  logic     du_vld, dv_vld;
  q_t       du_q, dv_q, dv_side;
  du_side_t du_side;

  effr_div #(.SW($bits(du_side_t))) u_div_u (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .num      (st.mom_x),
    .den      (st.rho),
    .side_in  ({normal_axis, st.rho, st.mom_x, st.mom_y}),
    .out_valid(du_vld),
    .quo      (du_q),
    .side_out (du_side)
  );

  effr_div #(.SW(Q_W)) u_div_v (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .num      (st.mom_y),
    .den      (st.rho),
    .side_in  (st.energy),
    .out_valid(dv_vld),
    .quo      (dv_q),
    .side_out (dv_side)
  );

  q_t un_c, ut_c;
  assign un_c = du_side.n ? du_q : dv_q;
  assign ut_c = du_side.n ? dv_q : du_q;

  // Stage A: squares and normal momentum
  logic  a_vld;
  base_t a_b;
  q_t    a_ut, a_uu, a_vv, a_rn;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= du_vld & dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_b  <= '{n: du_side.n, rho: du_side.rho, mx: du_side.mx, my: du_side.my,
                e: dv_side, un: un_c};
      a_ut <= ut_c;
      a_uu <= qmul(du_q, du_q);
      a_vv <= qmul(dv_q, dv_q);
      a_rn <= qmul(du_side.rho, un_c);
    end
  end

  // Stage B: speed squared, momentum flux products
  logic  b_vld;
  base_t b_b;
  q_t    b_q, b_rnun, b_ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_b    <= a_b;
      b_q    <= qadd(a_uu, a_vv);
      b_rnun <= qmul(a_rn, a_b.un);
      b_ft   <= qmul(a_rn, a_ut);
    end
  end

  // Stage C: kinetic energy
  logic  c_vld;
  base_t c_b;
  q_t    c_ke, c_rnun, c_ft, kq;

  assign kq = qmul(b_b.rho, b_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_b    <= b_b;
      c_ke   <= {kq[Q_W-1], kq[Q_W-1:1]};
      c_rnun <= b_rnun;
      c_ft   <= b_ft;
    end
  end

  // Stage D: internal energy
  logic  d_vld;
  base_t d_b;
  q_t    d_es, d_rnun, d_ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_b    <= c_b;
      d_es   <= qsub(c_b.e, c_ke);
      d_rnun <= c_rnun;
      d_ft   <= c_ft;
    end
  end

  // Stage E: pressure, floored at one LSB
  logic  e_vld;
  base_t e_b;
  q_t    e_p, e_rnun, e_ft, p_c;

  assign p_c = qmul(gm1, d_es);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_b    <= d_b;
      e_p    <= (p_c < 32'sd1) ? 32'sd1 : p_c;
      e_rnun <= d_rnun;
      e_ft   <= d_ft;
    end
  end

  // Stage F: gamma*p, normal flux, energy plus pressure
  logic  f_vld;
  base_t f_b;
  q_t    f_gp, f_fn, f_ep, f_ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_b  <= e_b;
      f_gp <= qmul(g_q, e_p);
      f_fn <= qadd(e_rnun, e_p);
      f_ep <= qadd(e_b.e, e_p);
      f_ft <= e_ft;
    end
  end

  // Stage G: energy flux
  logic  g_vld;
  base_t g_b;
  q_t    g_gp, g_fn, g_ft, g_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_b  <= f_b;
      g_gp <= f_gp;
      g_fn <= f_fn;
      g_ft <= f_ft;
      g_fe <= qmul(f_ep, f_b.un);
    end
  end

  // Sound speed: c^2 = gamma*p/rho, then square root
  logic  dc_vld;
  q_t    dc_q;
  tail_t dc_side;

  effr_div #(.SW($bits(tail_t))) u_div_c (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g_vld),
    .num      (g_gp),
    .den      (g_b.rho),
    .side_in  ({g_b, g_fn, g_ft, g_fe}),
    .out_valid(dc_vld),
    .quo      (dc_q),
    .side_out (dc_side)
  );

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  tail_t             sq_side;

  effr_sqrt #(.SW($bits(tail_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dc_vld),
    .x        (dc_q),
    .side_in  (dc_side),
    .out_valid(sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // Stage H: wave speed and flux placement by normal axis
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.st.rho    <= sq_side.b.rho;
      res.st.mom_x  <= sq_side.b.mx;
      res.st.mom_y  <= sq_side.b.my;
      res.st.energy <= sq_side.b.e;
      res.f_mass    <= sq_side.b.n ? sq_side.b.mx : sq_side.b.my;
      res.f_x       <= sq_side.b.n ? sq_side.fn : sq_side.ft;
      res.f_y       <= sq_side.b.n ? sq_side.ft : sq_side.fn;
      res.f_e       <= sq_side.fe;
      res.speed     <= qadd(qabs(sq_side.b.un), q_t'({{(Q_W-ROOT_W){1'b0}}, sq_root}));
    end
  end

endmodule

// ===== hw/rtl/euler_face_flux_rusanov_core.sv =====
// Rusanov flux across one face of a 2-D Euler grid, signed Q16.16 throughout.
// A fully pipelined datapath: one face is taken every cycle unless the flux
// channel stalls, with both cell sides evaluated side by side. Most of the
// pipeline depth is the three radix-2 dividers per side (34 stages each) and the
// 25-stage square root for the sound speed. A stall on the flux channel holds
// the whole pipeline; nothing is dropped. gamma sits at byte address 0 of the
// APB port and must only be written while no face is in flight.
`include "euler_face_flux_rusanov_core_defines.svh"

module euler_face_flux_rusanov_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_ready,
  input  effr_pkg::face_t  face,
  output logic             flux_valid,
  input  logic             flux_ready,
  output effr_pkg::flux_t  flux,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import effr_pkg::*;

  logic en;
  assign en         = !flux_valid || flux_ready;
  assign face_ready = en;

  // Configuration register
  logic [GAMMA_W-1:0] gamma;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAMMA) ? {{(32-GAMMA_W){1'b0}}, gamma} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAMMA)) begin
      gamma <= pwdata[GAMMA_W-1:0];
    end
  end

  // Slip-wall ghost and density floor
  state_t l_c, r_c, l_in, r_in;

  always_comb begin
    l_in = '{rho: face.left_density, mom_x: face.left_mom_x,
             mom_y: face.left_mom_y, energy: face.left_energy};
    r_in = '{rho: face.right_density, mom_x: face.right_mom_x,
             mom_y: face.right_mom_y, energy: face.right_energy};
    l_c  = l_in;
    r_c  = r_in;
    case (face.wall_mode)
      WALL_LEFT_GHOST: begin
        l_c = r_in;
        if (face.normal_axis) l_c.mom_x = qneg(r_in.mom_x);
        else l_c.mom_y = qneg(r_in.mom_y);
      end
      WALL_RIGHT_GHOST: begin
        r_c = l_in;
        if (face.normal_axis) r_c.mom_x = qneg(l_in.mom_x);
        else r_c.mom_y = qneg(l_in.mom_y);
      end
      default: begin
      end
    endcase
    if (l_c.rho < 32'sd1) l_c.rho = 32'sd1;
    if (r_c.rho < 32'sd1) r_c.rho = 32'sd1;
  end

  logic   s0_vld;
  logic   s0_n;
  state_t s0_l, s0_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= face_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_n <= face.normal_axis;
      s0_l <= l_c;
      s0_r <= r_c;
    end
  end

  // Per-side evaluation
  logic      l_vld, r_vld;
  side_res_t l_res, r_res;

  effr_side u_left (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .gamma      (gamma),
    .in_valid   (s0_vld),
    .normal_axis(s0_n),
    .st         (s0_l),
    .out_valid  (l_vld),
    .res        (l_res)
  );

  effr_side u_right (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .gamma      (gamma),
    .in_valid   (s0_vld),
    .normal_axis(s0_n),
    .st         (s0_r),
    .out_valid  (r_vld),
    .res        (r_res)
  );

  q_t l_f [0:3];
  q_t r_f [0:3];
  q_t l_u [0:3];
  q_t r_u [0:3];

  assign l_f = '{l_res.f_mass, l_res.f_x, l_res.f_y, l_res.f_e};
  assign r_f = '{r_res.f_mass, r_res.f_x, r_res.f_y, r_res.f_e};
  assign l_u = '{l_res.st.rho, l_res.st.mom_x, l_res.st.mom_y, l_res.st.energy};
  assign r_u = '{r_res.st.rho, r_res.st.mom_x, r_res.st.mom_y, r_res.st.energy};

  // C1: max wave speed, flux sums, state jumps
  logic                  c1_vld;
  q_t                    c1_alpha;
  logic signed [Q_W:0]   c1_sum [0:3];
  logic signed [Q_W:0]   c1_dif [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
    end else if (en) begin
      c1_vld <= l_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_alpha <= (l_res.speed > r_res.speed) ? l_res.speed : r_res.speed;
      for (int k = 0; k < 4; k++) begin
        c1_sum[k] <= {l_f[k][Q_W-1], l_f[k]} + {r_f[k][Q_W-1], r_f[k]};
        c1_dif[k] <= {r_u[k][Q_W-1], r_u[k]} - {l_u[k][Q_W-1], l_u[k]};
      end
    end
  end

  // C2: dissipation products and flux averages
  logic                    c2_vld;
  logic signed [2*Q_W:0]   c2_prod [0:3];
  q_t                      c2_avg  [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_vld <= 1'b0;
    end else if (en) begin
      c2_vld <= c1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        c2_prod[k] <= c1_alpha * c1_dif[k];
        c2_avg[k]  <= c1_sum[k][Q_W:1];
      end
    end
  end

  // C3: average minus dissipation, saturated
  q_t dis [0:3];
  q_t fo  [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dis[k] = sat48(c2_prod[k][2*Q_W:17]);
      fo[k]  = sat33({c2_avg[k][Q_W-1], c2_avg[k]} - {dis[k][Q_W-1], dis[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flux_valid <= 1'b0;
    end else if (en) begin
      flux_valid <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flux.flux_mass   <= fo[0];
      flux.flux_mom_x  <= fo[1];
      flux.flux_mom_y  <= fo[2];
      flux.flux_energy <= fo[3];
    end
  end

  `EFFR_ASSERT(a_sides_aligned, l_vld == r_vld)
  `EFFR_ASSERT_IMPL(a_rho_floored, l_vld, l_res.st.rho > 0 && r_res.st.rho > 0)
  `EFFR_ASSERT_IMPL(a_alpha_nonneg, c1_vld, !c1_alpha[Q_W-1])
  `EFFR_ASSERT_NEXT(a_stall_holds, c2_vld && !en, c2_vld && $stable(c2_avg[0]))

endmodule

// ===== sim/tb_euler_face_flux_rusanov_core.sv =====
module tb_euler_face_flux_rusanov_core;
  timeunit 1ns;
  timeprecision 1ps;
  import effr_pkg::*;

  localparam int LATENCY = 105;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic face_valid, face_ready, flux_valid, flux_ready;
  face_t face;
  flux_t flux;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  euler_face_flux_rusanov_core uut (
    .clk(clk), .rst(rst), .face_valid(face_valid), .face_ready(face_ready), .face(face),
    .flux_valid(flux_valid), .flux_ready(flux_ready), .flux(flux),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  face_t pending_faces[$];
  flux_t expected_fluxes[$];
  longint gamma_q;
  int errors = 0;
  longint cycle_count = 0;
  bit send_idle_en = 1, recv_idle_en = 1;
  int recv_hold = 0;
  bit face_taken = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Fixed-point helpers over 64-bit containers
  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fshr(longint x, int k);
    return x >>> k;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return sat(fshr(a * b, 16));
  endfunction

  function automatic longint fdiv(longint a, longint b);
    return sat((a * 65536) / b);
  endfunction

  function automatic longint root(longint x);
    longint r, bt;
    r = 0;
    bt = 64'sd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // Evaluate one side: floors density in place, returns physical flux and wave speed
  function automatic void eval_side(inout longint s[4], input int n, output longint fl[4],
                                    output longint speed);
    int t;
    longint vel[3], q, ke, p, rn, cc, rho;
    t = (n == 1) ? 2 : 1;
    rho = (s[0] < 1) ? 1 : s[0];
    s[0] = rho;
    vel[0] = 0;
    vel[1] = fdiv(s[1], rho);
    vel[2] = fdiv(s[2], rho);
    q = sat(fmul(vel[1], vel[1]) + fmul(vel[2], vel[2]));
    ke = fshr(fmul(rho, q), 1);
    p = fmul(gamma_q - 65536, sat(s[3] - ke));
    if (p < 1) p = 1;
    cc = fdiv(fmul(gamma_q, p), rho);
    if (cc < 0) cc = 0;
    rn = fmul(rho, vel[n]);
    fl[0] = s[n];
    fl[n] = sat(fmul(rn, vel[n]) + p);
    fl[t] = fmul(rn, vel[t]);
    fl[3] = fmul(sat(s[3] + p), vel[n]);
    speed = sat(sat(vel[n] < 0 ? -vel[n] : vel[n]) + root(cc * 65536));
  endfunction

  function automatic flux_t predict_flux(face_t f);
    longint lft[4], rgt[4], fl[4], fr[4], sl, sr, alpha, avg, dis;
    int n;
    flux_t r;
    longint o[4];
    lft[0] = f.left_density;  lft[1] = f.left_mom_x;
    lft[2] = f.left_mom_y;    lft[3] = f.left_energy;
    rgt[0] = f.right_density; rgt[1] = f.right_mom_x;
    rgt[2] = f.right_mom_y;   rgt[3] = f.right_energy;
    n = f.normal_axis ? 1 : 2;
    if (f.wall_mode == WALL_LEFT_GHOST) begin
      lft = rgt;
      lft[n] = sat(-lft[n]);
    end else if (f.wall_mode == WALL_RIGHT_GHOST) begin
      rgt = lft;
      rgt[n] = sat(-rgt[n]);
    end
    eval_side(lft, n, fl, sl);
    eval_side(rgt, n, fr, sr);
    alpha = (sl > sr) ? sl : sr;
    for (int k = 0; k < 4; k++) begin
      avg = fshr(fl[k] + fr[k], 1);
      dis = sat(fshr(alpha * (rgt[k] - lft[k]), 17));
      o[k] = sat(avg - dis);
    end
    r.flux_mass = o[0][31:0];
    r.flux_mom_x = o[1][31:0];
    r.flux_mom_y = o[2][31:0];
    r.flux_energy = o[3][31:0];
    return r;
  endfunction

  // Driver: present queued faces, idle at random, advance only after a transaction
  always @(negedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
    end else if (!face_valid || face_taken) begin
      if (face_taken) void'(pending_faces.pop_front());
      if (pending_faces.size() > 0 &&
          !(send_idle_en && $urandom_range(99) < 29)) begin
        face_valid <= 1'b1;
        face <= pending_faces[0];
      end else begin
        face_valid <= 1'b0;
      end
    end
  end

  // Record expectation at acceptance
  always @(posedge clk) begin
    face_taken <= !rst && face_valid && face_ready;
    if (!rst && face_valid && face_ready) expected_fluxes.push_back(predict_flux(face));
  end

  // Receiver ready control
  always @(negedge clk) begin
    if (rst) begin
      flux_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      flux_ready <= 1'b0;
    end else begin
      flux_ready <= !(recv_idle_en && $urandom_range(99) < 29);
    end
  end

  // Monitor: compare each accepted flux with the oldest expectation
  always @(posedge clk) begin
    flux_t exp_f;
    cycle_count <= cycle_count + 1;
    if (!rst && flux_valid && flux_ready) begin
      if (expected_fluxes.size() == 0) begin
        $display("%0t: unexpected flux transaction %h", $time, flux);
        errors++;
      end else begin
        exp_f = expected_fluxes.pop_front();
        if (flux.flux_mass !== exp_f.flux_mass) begin
          $display("%0t: flux_mass exp %h got %h", $time, exp_f.flux_mass, flux.flux_mass);
          errors++;
        end
        if (flux.flux_mom_x !== exp_f.flux_mom_x) begin
          $display("%0t: flux_mom_x exp %h got %h", $time, exp_f.flux_mom_x,
                   flux.flux_mom_x);
          errors++;
        end
        if (flux.flux_mom_y !== exp_f.flux_mom_y) begin
          $display("%0t: flux_mom_y exp %h got %h", $time, exp_f.flux_mom_y,
                   flux.flux_mom_y);
          errors++;
        end
        if (flux.flux_energy !== exp_f.flux_energy) begin
          $display("%0t: flux_energy exp %h got %h", $time, exp_f.flux_energy,
                   flux.flux_energy);
          errors++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_faces.size() > 0 || face_valid || expected_fluxes.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_gamma(logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    gamma_q = val & 32'h3FFFF;
    // read back
    @(negedge clk);
    psel <= 1; paddr <= 3'd0;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata[17:0] !== gamma_q[17:0]) begin
      $display("%0t: gamma readback exp %h got %h", $time, gamma_q[17:0], prdata[17:0]);
      errors++;
    end
    @(negedge clk);
    psel <= 0; penable <= 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return $urandom_range(0, 32'h00040000);
      default: return $urandom_range(0, 32'h00200000) - 32'h00100000;
    endcase
  endfunction

  // Mostly a physical state (positive density, moderate momentum, positive energy), else arbitrary words
  function automatic face_t rand_face();
    face_t f;
    logic [31:0] w;
    f = '0;
    f.normal_axis = ($urandom_range(1) == 1);
    if ($urandom_range(99) < 75) begin
      f.left_density = $urandom_range(32'h00004000, 32'h00080000);
      f.right_density = $urandom_range(32'h00004000, 32'h00080000);
      f.left_mom_x = $urandom_range(0, 32'h00040000) - 32'h00020000;
      f.left_mom_y = $urandom_range(0, 32'h00040000) - 32'h00020000;
      f.right_mom_x = $urandom_range(0, 32'h00040000) - 32'h00020000;
      f.right_mom_y = $urandom_range(0, 32'h00040000) - 32'h00020000;
      f.left_energy = $urandom_range(32'h00010000, 32'h00400000);
      f.right_energy = $urandom_range(32'h00010000, 32'h00400000);
    end else begin
      f.left_density = rand_word();  f.left_mom_x = rand_word();
      f.left_mom_y = rand_word();    f.left_energy = rand_word();
      f.right_density = rand_word(); f.right_mom_x = rand_word();
      f.right_mom_y = rand_word();   f.right_energy = rand_word();
    end
    w = $urandom_range(9);
    f.wall_mode = (w < 6) ? WALL_INTERIOR :
                  (w < 8 ? WALL_LEFT_GHOST : (w == 8 ? WALL_RIGHT_GHOST : WALL_UNUSED));
    return f;
  endfunction

  task automatic add_directed();
    face_t f;
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1};
    for (int i = 0; i < 16; i++) begin
      f.left_density = ext[i % 4];      f.left_mom_x = ext[(i + 1) % 4];
      f.left_mom_y = ext[(i + 2) % 4];  f.left_energy = ext[(i + 3) % 4];
      f.right_density = ext[(i / 4) % 4]; f.right_mom_x = ext[(i + 3) % 4];
      f.right_mom_y = ext[(i / 2) % 4]; f.right_energy = ext[(i + 2) % 4];
      f.normal_axis = i[0];
      f.wall_mode = i[3:2];
      pending_faces.push_back(f);
    end
    // ghosts with most negative normal momentum, negative pressure, negative density
    f = '0;
    f.left_density = 32'h00010000; f.left_mom_x = 32'h80000000; f.left_energy = 32'hffff0000;
    f.right_density = 32'hfff00000; f.right_mom_y = 32'h80000000;
    for (int m = 0; m < 4; m++) begin
      f.wall_mode = m[1:0];
      f.normal_axis = m[0];
      pending_faces.push_back(f);
    end
    f.normal_axis = 0; f.wall_mode = WALL_LEFT_GHOST;
    pending_faces.push_back(f);
  endtask

  task automatic add_random(int count);
    for (int i = 0; i < count; i++) pending_faces.push_back(rand_face());
  endtask

  initial begin
    logic [31:0] gammas[5];
    rst = 1;
    face_valid = 0; face = '0; flux_ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    gamma_q = 91750;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed faces at reset gamma
    add_directed();
    wait_drained();

    gammas = '{32'd65537, 32'd196608, 32'd91750, 32'd110000, 32'd3000};
    for (int ph = 0; ph < 5; ph++) begin
      write_gamma(ph == 4 ? {14'h0, 18'd30000} | 32'hfffc0000 : gammas[ph]);
      if (ph == 1) begin
        // Hold the receiver off long while the sender keeps offering
        send_idle_en = 0;
        @(negedge clk);
        recv_hold = 400;
        add_random(300);
        wait_drained();
        send_idle_en = 1;
      end else if (ph == 2) begin
        // Stretch with no idling on either side
        send_idle_en = 0; recv_idle_en = 0;
        add_random(300);
        wait_drained();
        send_idle_en = 1; recv_idle_en = 1;
      end else begin
        add_random(ph == 4 ? 200 : 300);
        wait_drained();
      end
    end
    add_random(300);
    wait_drained();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
